// ----- design/assert_macros.svh -----
// Assertion helpers included by the probe request table top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, prop) \
    label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("%m failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
    label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// ----- design/prt_pkg.sv -----
// ----------------------------------------------------------------------------
// Probe request table package
// Shared constants, codes and the cell interface types.
// ----------------------------------------------------------------------------
`default_nettype none
package prt_pkg;
    localparam int TABLE_ENTRIES  = 64;
    localparam int SSID_MAX_BYTES = 32;
    localparam int SLOT_W         = 6;
    localparam int TOTAL_W        = 7;
    localparam int LEN_W          = 6;
    localparam int HDR_LEN        = 24;

    localparam logic [1:0] REQ_BYTE  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [1:0] KIND_VERDICT = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_SSID    = 2'd2;

    localparam logic [3:0] ST_INSERTED = 4'd0;
    localparam logic [3:0] ST_UPDATED  = 4'd1;
    localparam logic [3:0] ST_FULL     = 4'd2;
    localparam logic [3:0] ST_SHORT    = 4'd3;
    localparam logic [3:0] ST_NOTPROBE = 4'd4;
    localparam logic [3:0] ST_GROUP    = 4'd5;
    localparam logic [3:0] ST_NOELEM   = 4'd6;
    localparam logic [3:0] ST_NOTSSID  = 4'd7;
    localparam logic [3:0] ST_WILDCARD = 4'd8;
    localparam logic [3:0] ST_OVERRUN  = 4'd9;

    typedef struct packed {
        logic [47:0]                  mac;
        logic [LEN_W-1:0]             len;
        logic [SSID_MAX_BYTES*8-1:0]  ssid;
    } t_key;

    typedef struct packed {
        logic        valid;
        logic [47:0] mac;
        logic [7:0]  dbm;
        logic [31:0] cnt;
        logic [31:0] tms;
        logic [LEN_W-1:0] len;
    } t_entry;

    // Search token that walks along the row of cells.
    typedef struct packed {
        logic              active;
        logic              hit;
        logic [SLOT_W-1:0] slot;
        t_entry            ent;
    } t_probe;
endpackage
`default_nettype wire

// ----- design/probe_request_table_top.sv -----
// ----------------------------------------------------------------------------
// Probe request table
// Parses probe requests and keeps a table of station and SSID pairs.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         tdata: frame_byte, signal_dbm, now_ms, entry_index;
//                      tlast: frame_last; tuser: req_type
// m_axis    out        tdata: result fields; tlast: last; tuser: result_kind
// cfg       in         capture_enable write
// After the last byte of a frame that passes the checks, the parser registers
// its verdict, the search token walks the row of cells, and the result is put
// out before the next transaction; a rejected frame goes straight to its result.
// A read gives one result for the header and each SSID byte, each held until
// taken. Reset empties the table at once. Input is held off while a transaction
// is being worked on or its results wait.
`default_nettype none
module probe_request_table_top
    import prt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // frame_byte[7:0], signal_dbm[15:8], now_ms[47:16], entry_index[53:48]
    input  wire logic [55:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,
    // req_type[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // frame_status[3:0], entry_slot[9:4], client_mac[57:10], best_dbm[65:58],
    // seen_count[97:66], last_seen_ms[129:98], ssid_length[135:130],
    // ssid_byte[143:136], entry_valid[144], entry_total[151:145]
    output logic [151:0]     m_axis_tdata,
    output logic             m_axis_tlast,
    // result_kind[1:0]
    output logic [1:0]       m_axis_tuser
);
    `include "assert_macros.svh"

    typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_READ, S_OUT} t_state;

    t_state            r_state;
    logic              r_cap_en;
    logic [TOTAL_W-1:0] r_count;
    logic [7:0]        r_dbm;
    logic [31:0]       r_tms;
    logic [SLOT_W-1:0] r_idx;
    logic [LEN_W-1:0]  r_k;
    logic              r_clear;
    logic              w_acc;
    logic              w_byte_en;
    logic              w_drop;
    logic              w_done;
    logic [3:0]        w_status;
    t_key              w_key;
    t_probe            w_chain [TABLE_ENTRIES+1];
    t_entry            w_ent  [TABLE_ENTRIES];
    logic [SSID_MAX_BYTES*8-1:0] w_ssid [TABLE_ENTRIES];
    t_entry            w_fin_ent;
    logic [3:0]        r_st;
    logic [1:0]        r_kind;
    logic [SLOT_W-1:0] r_slot;
    t_entry            r_oent;
    logic [7:0]        r_sbyte;
    logic              r_last;

    assign w_acc     = s_axis_tvalid && s_axis_tready;
    assign w_byte_en = w_acc && s_axis_tuser == REQ_BYTE && r_cap_en;
    assign w_drop    = w_acc && s_axis_tuser == REQ_BYTE && !r_cap_en;
    assign s_axis_tready = (r_state == S_IDLE) && !w_done;

    prt_parser u_parser (
        .i_clk, .i_rst_n, .i_en(w_byte_en), .i_drop(w_drop), .i_byte(s_axis_tdata[7:0]),
        .i_last(s_axis_tlast), .o_done(w_done), .o_status(w_status), .o_key(w_key)
    );

    always_comb begin
        w_chain[0]        = '0;
        w_chain[0].active = w_done && w_status == ST_INSERTED;
    end

    always_comb begin
        w_fin_ent       = w_chain[TABLE_ENTRIES].ent;
        w_fin_ent.valid = 1'b1;
    end

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        prt_cell u_cell (
            .i_clk, .i_rst_n, .i_my_slot(SLOT_W'(g)), .i_clear(r_clear),
            .i_key(w_key), .i_dbm(r_dbm), .i_tms(r_tms), .i_count(r_count),
            .i_probe(w_chain[g]), .o_probe(w_chain[g+1]), .o_ssid(w_ssid[g]),
            .o_ent(w_ent[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_cap_en <= 1'b0; r_count <= '0; r_clear <= 1'b0;
        end else begin
            r_clear <= 1'b0;
            if (i_cfg_we) r_cap_en <= i_cfg_wdata;
            case (r_state)
                S_IDLE: begin
                    if (w_done) begin
                        if (w_status == ST_INSERTED) r_state <= S_SEARCH;
                        else begin
                            r_kind <= KIND_VERDICT; r_st <= w_status; r_slot <= '0;
                            r_oent <= '0; r_sbyte <= '0; r_last <= 1'b1;
                            r_state <= S_OUT;
                        end
                    end else if (w_acc && s_axis_tuser == REQ_READ) begin
                        r_idx <= s_axis_tdata[53:48]; r_k <= '0; r_state <= S_READ;
                    end else if (w_acc && s_axis_tuser == REQ_CLEAR) begin
                        r_count <= '0; r_clear <= 1'b1;
                    end
                    if (w_byte_en && s_axis_tlast) begin
                        r_dbm <= s_axis_tdata[15:8]; r_tms <= s_axis_tdata[47:16];
                    end
                end
                S_SEARCH: begin
                    if (w_chain[TABLE_ENTRIES].active) begin
                        r_kind <= KIND_VERDICT; r_sbyte <= '0; r_last <= 1'b1;
                        if (!w_chain[TABLE_ENTRIES].hit) begin
                            r_st <= ST_FULL; r_slot <= '0; r_oent <= '0;
                        end else begin
                            r_slot <= w_chain[TABLE_ENTRIES].slot;
                            r_oent <= w_fin_ent;
                            r_st <= w_chain[TABLE_ENTRIES].ent.valid ? ST_INSERTED
                                                                      : ST_UPDATED;
                            if (w_chain[TABLE_ENTRIES].ent.valid)
                                r_count <= r_count + TOTAL_W'(1);
                        end
                        r_state <= S_OUT;
                    end
                end
                S_READ: begin
                    r_st <= ST_INSERTED; r_slot <= r_idx;
                    r_kind <= (r_k == '0) ? KIND_HEADER : KIND_SSID;
                    if ({1'b0, r_idx} >= r_count) begin
                        r_oent <= '0; r_sbyte <= '0; r_last <= 1'b1;
                    end else begin
                        r_oent <= w_ent[r_idx];
                        r_sbyte <= (r_k == '0) ? 8'h00 : w_ssid[r_idx][(r_k-LEN_W'(1))*8 +: 8];
                        r_last <= (r_k == w_ent[r_idx].len);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        if (r_kind != KIND_VERDICT && !r_last) begin
                            r_k <= r_k + LEN_W'(1); r_state <= S_READ;
                        end else r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tuser  = r_kind;
    assign m_axis_tlast  = r_last;
    assign m_axis_tdata  = {r_count, r_oent.valid, r_sbyte, r_oent.len, r_oent.tms,
                            r_oent.cnt, r_oent.dbm, r_oent.mac, r_slot, r_st};

    `ASSERT_NEVER(a_ready_busy, i_clk, !i_rst_n, s_axis_tready && r_state != S_IDLE)
    `ASSERT_IMPL(a_total_max, i_clk, !i_rst_n, r_count <= TOTAL_W'(TABLE_ENTRIES))
    `ASSERT_IMPL(a_done_idle, i_clk, !i_rst_n, w_done |-> r_state == S_IDLE)
endmodule
`default_nettype wire

// ----- design/prt_cell.sv -----
// ----------------------------------------------------------------------------
// Probe request table cell
// Holds one table entry and compares, fills or updates it as the probe passes by.
// ----------------------------------------------------------------------------
`default_nettype none
module prt_cell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [prt_pkg::SLOT_W-1:0]  i_my_slot,
    input  wire logic                i_clear,
    input  wire prt_pkg::t_key       i_key,
    input  wire logic [7:0]          i_dbm,
    input  wire logic [31:0]         i_tms,
    input  wire logic [prt_pkg::TOTAL_W-1:0] i_count,
    input  wire prt_pkg::t_probe     i_probe,
    output prt_pkg::t_probe          o_probe,
    output logic [prt_pkg::SSID_MAX_BYTES*8-1:0] o_ssid,
    output prt_pkg::t_entry          o_ent
);
    import prt_pkg::*;

    logic                       r_used;
    t_entry                     r_ent;
    logic [SSID_MAX_BYTES*8-1:0] r_ssid;
    t_probe                     r_probe;
    logic                       w_match;
    logic                       w_ins;
    t_probe                     n_probe;

    assign w_match = i_probe.active && !i_probe.hit && r_used &&
                     r_ent.mac == i_key.mac && r_ent.len == i_key.len &&
                     r_ssid == i_key.ssid;
    assign w_ins = i_probe.active && !i_probe.hit && !r_used &&
                   {1'b0, i_my_slot} == i_count;

    always_comb begin
        n_probe = i_probe;
        if (w_match) begin
            n_probe.hit       = 1'b1;
            n_probe.slot      = i_my_slot;
            n_probe.ent       = r_ent;
            n_probe.ent.valid = 1'b0;
            n_probe.ent.tms   = i_tms;
            if (r_ent.cnt != 32'hFFFF_FFFF) n_probe.ent.cnt = r_ent.cnt + 32'd1;
            if ($signed(i_dbm) > $signed(r_ent.dbm)) n_probe.ent.dbm = i_dbm;
        end else if (w_ins) begin
            n_probe.hit       = 1'b1;
            n_probe.slot      = i_my_slot;
            n_probe.ent.valid = 1'b1;
            n_probe.ent.mac   = i_key.mac;
            n_probe.ent.dbm   = i_dbm;
            n_probe.ent.cnt   = 32'd1;
            n_probe.ent.tms   = i_tms;
            n_probe.ent.len   = i_key.len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_used  <= 1'b0;
            r_probe <= '0;
        end else begin
            r_probe <= n_probe;
            if (w_ins) r_used <= 1'b1;
        end
        if (w_match) begin
            r_ent.tms <= n_probe.ent.tms;
            r_ent.cnt <= n_probe.ent.cnt;
            r_ent.dbm <= n_probe.ent.dbm;
        end else if (w_ins) begin
            r_ent  <= n_probe.ent;
            r_ssid <= i_key.ssid;
        end
    end

    assign o_probe = r_probe;
    assign o_ssid  = r_ssid;
    assign o_ent   = r_ent;
endmodule
`default_nettype wire

// ----- design/prt_parser.sv -----
// ----------------------------------------------------------------------------
// Probe request frame parser
// Captures header fields and SSID bytes and grades the frame at its end.
// ----------------------------------------------------------------------------
`default_nettype none
module prt_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_drop,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_last,
    output logic             o_done,
    output logic [3:0]       o_status,
    output prt_pkg::t_key    o_key
);
    import prt_pkg::*;

    logic [11:0] r_pos;
    logic [7:0]  r_ctl;
    logic [47:0] r_src;
    logic [7:0]  r_tag;
    logic [7:0]  r_elen;
    logic [7:0]  r_cap [SSID_MAX_BYTES];
    logic [7:0]  w_ctl;
    logic [47:0] w_src;
    logic [7:0]  w_tag;
    logic [7:0]  w_elen;
    logic [12:0] w_len;
    logic [7:0]  w_c;
    logic [5:0]  w_n;
    logic        r_done;
    logic [3:0]  r_status;
    t_key        r_key;
    logic [3:0]  n_status;
    logic [SSID_MAX_BYTES*8-1:0] n_ssid;

    always_comb begin
        w_ctl  = (r_pos == 12'd0) ? i_byte : r_ctl;
        w_src  = (r_pos >= 12'd10 && r_pos <= 12'd15) ? {r_src[39:0], i_byte} : r_src;
        w_tag  = (r_pos == 12'(HDR_LEN)) ? i_byte : r_tag;
        w_elen = (r_pos == 12'(HDR_LEN + 1)) ? i_byte : r_elen;
        w_len  = {1'b0, r_pos} + 13'd1;
        w_n    = (w_elen < 8'(SSID_MAX_BYTES)) ? w_elen[5:0] : 6'(SSID_MAX_BYTES);
        if (w_len < 13'(HDR_LEN))                            n_status = ST_SHORT;
        else if (w_ctl != 8'h40)                             n_status = ST_NOTPROBE;
        else if (w_src[47:40] == 8'hFF || w_src[40])         n_status = ST_GROUP;
        else if (w_len <= 13'(HDR_LEN + 2))                  n_status = ST_NOELEM;
        else if (w_tag != 8'h00)                             n_status = ST_NOTSSID;
        else if (w_elen == 8'h00)                            n_status = ST_WILDCARD;
        else if (13'(HDR_LEN + 2) + {5'd0, w_elen} > w_len)  n_status = ST_OVERRUN;
        else                                                 n_status = ST_INSERTED;
        w_c    = 8'h00;
        n_ssid = '0;
        for (int k = 0; k < SSID_MAX_BYTES; k++) begin
            if (k == int'(r_pos) - (HDR_LEN + 2)) w_c = i_byte;
            else w_c = r_cap[k];
            if (6'(k) < w_n) n_ssid[k*8 +: 8] = (w_c < 8'h20) ? 8'h3F : w_c;
            else n_ssid[k*8 +: 8] = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_ctl <= '0; r_src <= '0; r_tag <= '0; r_elen <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_en) begin
                r_ctl <= w_ctl; r_src <= w_src; r_tag <= w_tag; r_elen <= w_elen;
                if (i_last) begin
                    r_pos  <= '0;
                    r_done <= 1'b1;
                end else if (r_pos != 12'hFFF) begin
                    r_pos <= r_pos + 12'd1;
                end
            end else if (i_drop) begin
                r_pos <= '0;
            end
        end
        if (i_en && r_pos >= 12'(HDR_LEN + 2) && r_pos < 12'(HDR_LEN + 2 + SSID_MAX_BYTES))
            r_cap[5'(r_pos - 12'(HDR_LEN + 2))] <= i_byte;
        if (i_en && i_last) begin
            r_status   <= n_status;
            r_key.mac  <= w_src;
            r_key.len  <= w_n;
            r_key.ssid <= n_ssid;
        end
    end

    assign o_done   = r_done;
    assign o_status = r_status;
    assign o_key    = r_key;
endmodule
`default_nettype wire
